>>> sv/drpc_pkg.sv
package drpc_pkg;

  // Field and datapath widths
  localparam int COORD_W   = 16;
  localparam int ID_W      = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int GUARD     = 8;
  localparam int XW        = DIFF_W + GUARD + 3;
  localparam int ZW        = 24;
  localparam int ANG_FRAC  = 20;
  localparam int ANGLE_W   = 16;
  localparam int RADIUS_W  = 21;
  localparam int GAIN_W    = 20;
  localparam int PROD_W    = XW - 1 + GAIN_W;
  localparam int CFG_IDX_W = 2;
  localparam int TABLE_LEN = 24;

  localparam logic [GAIN_W-1:0]   GAIN_Q20    = 20'd636751;
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX  = {RADIUS_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPOT_X     = 2'd0,
    REG_DEPOT_Y     = 2'd1,
    REG_DEPOT_INDEX = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]           node_index;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } node_t;

  typedef struct packed {
    logic [ID_W-1:0]           node_id_out;
    logic [RADIUS_W-1:0]       radius;
    logic signed [ANGLE_W-1:0] angle;
    logic                      is_depot;
  } result_t;

  // One CORDIC pipeline slot
  typedef struct packed {
    logic                 valid;
    logic                 is_depot;
    logic                 force_zero;
    logic [ID_W-1:0]      node_id;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-i) in Q20
  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 24'sd823550;
      1:       v = 24'sd486170;
      2:       v = 24'sd256879;
      3:       v = 24'sd130396;
      4:       v = 24'sd65451;
      5:       v = 24'sd32757;
      6:       v = 24'sd16383;
      7:       v = 24'sd8192;
      8:       v = 24'sd4096;
      9:       v = 24'sd2048;
      10:      v = 24'sd1024;
      11:      v = 24'sd512;
      12:      v = 24'sd256;
      13:      v = 24'sd128;
      14:      v = 24'sd64;
      15:      v = 24'sd32;
      16:      v = 24'sd16;
      17:      v = 24'sd8;
      18:      v = 24'sd4;
      19:      v = 24'sd2;
      20:      v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/drpc_cordic_stage.sv
module drpc_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  drpc_pkg::cordic_t in_s,
  output drpc_pkg::cordic_t out_s
);
  import drpc_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_I = atan_q20(STAGE);

  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cordic_t              out_next;

  assign x_in = in_s.x;
  assign y_in = in_s.y;
  assign xs   = x_in >>> STAGE;
  assign ys   = y_in >>> STAGE;

  // Rotate toward the x axis, both updates from the old x and y
  always_comb begin
    out_next = in_s;
    if (!y_in[XW-1]) begin
      out_next.x = x_in + ys;
      out_next.y = y_in - xs;
      out_next.z = in_s.z + ATAN_I;
    end else begin
      out_next.x = x_in - ys;
      out_next.y = y_in + xs;
      out_next.z = in_s.z - ATAN_I;
    end
  end

  // Advance one slot; clear it on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_s <= '0;
    end else begin
      out_s <= out_next;
    end
  end

endmodule

>>> sv/depot_relative_polar_convert.sv
// Depot-relative polar conversion.
// Each transfer on the command channel (start high while busy is low) carries
// one node: index and signed x, y. The block subtracts the configured depot
// position and returns the distance (unsigned Q17.4) and atan2 angle (signed
// radians Q2.13) from a pipelined CORDIC vectoring unit with a constant gain
// correction multiply. A node whose index matches the depot index returns
// radius 0, angle 0 and is_depot set.
// Configuration: cfg_valid/cfg_ready write depot_x (0), depot_y (1) and
// depot_index (2); other indexes are ignored. Write only while no node is in
// flight.
// Pipeline: difference, pre-rotation, one register per CORDIC iteration, gain
// multiply, then rounding and saturation into the output register, where done
// rises together with the result.
// Throughput: one node per cycle; busy is low except during reset.
// Each result shows on result for exactly one cycle with done high; the
// receiver cannot stall, so nothing is ever held back.
// Reset: clears all in-flight nodes and loads depot_x = 0, depot_y = 0,
// depot_index = 1.
module depot_relative_polar_convert #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  drpc_pkg::node_t                       node,
  output logic                                  done,
  output drpc_pkg::result_t                     result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [drpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [drpc_pkg::COORD_W-1:0]          cfg_data
);
  import drpc_pkg::*;

  logic signed [COORD_W-1:0] depot_x;
  logic signed [COORD_W-1:0] depot_y;
  logic [ID_W-1:0]           depot_index;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depot_x     <= '0;
      depot_y     <= '0;
      depot_index <= ID_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEPOT_X:     depot_x     <= cfg_data;
        REG_DEPOT_Y:     depot_y     <= cfg_data;
        REG_DEPOT_INDEX: depot_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: offsets from the depot and depot match
  logic                      s1_valid;
  logic                      s1_depot;
  logic [ID_W-1:0]           s1_id;
  logic signed [DIFF_W-1:0]  s1_dx;
  logic signed [DIFF_W-1:0]  s1_dy;

  always_ff @(posedge clk) begin
    s1_id    <= node.node_index;
    s1_depot <= (node.node_index == depot_index);
    s1_dx    <= DIFF_W'(node.x_coord) - DIFF_W'(depot_x);
    s1_dy    <= DIFF_W'(node.y_coord) - DIFF_W'(depot_y);
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  // Stage 2: fold into the right half plane and scale by the guard bits
  cordic_t                  pipe [CORDIC_STAGES+1];
  cordic_t                  pre_next;
  cordic_t                  pre_q;
  logic signed [DIFF_W-1:0] x0;
  logic signed [DIFF_W-1:0] y0;
  logic signed [ZW-1:0]     z0;

  always_comb begin
    if (!s1_dx[DIFF_W-1]) begin
      x0 = s1_dx;
      y0 = s1_dy;
      z0 = '0;
    end else if (!s1_dy[DIFF_W-1]) begin
      x0 = s1_dy;
      y0 = -s1_dx;
      z0 = HALF_PI_Q20;
    end else begin
      x0 = -s1_dy;
      y0 = s1_dx;
      z0 = -HALF_PI_Q20;
    end
    pre_next.valid      = s1_valid;
    pre_next.is_depot   = s1_depot;
    pre_next.force_zero = s1_depot || (s1_dx == '0 && s1_dy == '0);
    pre_next.node_id    = s1_id;
    pre_next.x          = XW'(x0) <<< GUARD;
    pre_next.y          = XW'(y0) <<< GUARD;
    pre_next.z          = z0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_q <= '0;
    end else begin
      pre_q <= pre_next;
    end
  end

  assign pipe[0] = pre_q;

  // CORDIC iterations, one register stage each
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    drpc_cordic_stage #(
      .STAGE(i)
    ) u_stage (
      .clk  (clk),
      .rst  (rst),
      .in_s (pipe[i]),
      .out_s(pipe[i+1])
    );
  end

  // Gain correction multiply
  cordic_t               last;
  logic [XW-2:0]         x_pos;
  logic                  m_valid;
  logic                  m_depot;
  logic                  m_zero;
  logic [ID_W-1:0]       m_id;
  logic [PROD_W-1:0]     m_prod;
  logic signed [ZW-1:0]  m_z;

  assign last  = pipe[CORDIC_STAGES];
  assign x_pos = last.x[XW-1] ? '0 : last.x[XW-2:0];

  always_ff @(posedge clk) begin
    m_depot <= last.is_depot;
    m_zero  <= last.force_zero;
    m_id    <= last.node_id;
    m_prod  <= PROD_W'(x_pos) * PROD_W'(GAIN_Q20);
    m_z     <= last.z;
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= last.valid;
    end
  end

  // Round and saturate both outputs
  logic [PROD_W:0]        r_sum;
  logic [PROD_W-24:0]     r_q;
  logic [RADIUS_W-1:0]    radius_sat;
  logic signed [ZW:0]     z_sum;
  logic signed [ZW-7:0]   a_q;
  logic signed [ANGLE_W-1:0] angle_sat;
  result_t                result_next;

  localparam logic signed [ZW-7:0] ANGLE_MAX = (ZW-6)'(32767);
  localparam logic signed [ZW-7:0] ANGLE_MIN = -(ZW-6)'(32768);

  always_comb begin
    r_sum = {1'b0, m_prod} + (PROD_W+1)'(24'h800000);
    r_q   = r_sum[PROD_W:24];
    if (r_q > (PROD_W-23)'(RADIUS_MAX)) begin
      radius_sat = RADIUS_MAX;
    end else begin
      radius_sat = r_q[RADIUS_W-1:0];
    end
    z_sum = (ZW+1)'(m_z) + (ZW+1)'(64);
    a_q   = z_sum[ZW:ANG_FRAC-13];
    priority if (a_q > ANGLE_MAX) begin
      angle_sat = 16'sh7fff;
    end else if (a_q < ANGLE_MIN) begin
      angle_sat = 16'sh8000;
    end else begin
      angle_sat = a_q[ANGLE_W-1:0];
    end
    result_next.node_id_out = m_id;
    result_next.is_depot    = m_depot;
    result_next.radius      = m_zero ? '0 : radius_sat;
    result_next.angle       = m_zero ? '0 : angle_sat;
  end

  // Output register: one-cycle result strobe
  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
  end

endmodule
